// ===== rtl/nca_pkg.sv =====
// Shared constants and codes for the nearest center assignment block.
package nca_pkg;

  localparam int MaxCentersDef = 64;
  localparam int MaxDimDef     = 64;

  localparam int ValueW = 16;
  localparam int MagW   = 16;
  localparam int SqW    = 32;
  localparam int SumW   = 38;
  localparam int CfgW   = 7;
  localparam int IdxW   = 6;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdFrame = 1'b1;

  localparam logic RegNumCenters   = 1'b0;
  localparam logic RegVectorLength = 1'b1;

endpackage

// ===== rtl/nca_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/nearest_center_assign.sv =====
// Top level of the nearest center assignment block: control, pipeline and memories.
//
// Usage: the APB port sets num_centers (address 0) and vector_length (address 4);
// both are clamped to their legal range when used, and a write abandons the frame
// in progress. Items enter on start while busy is low. A load beat (command 0)
// writes one center coordinate into the center memory. A frame beat (command 1)
// carries the next coordinate of the current frame; it updates the accumulator of
// every center in use, one center per cycle through one shared subtract, square
// and add path, so busy stays high until the accumulator of the last center is
// written, and the next item is taken once busy is low again. The loop over the
// centers is bounded by the single read port of the center memory and of the
// accumulator memory. After the last coordinate of a frame, done_o pulses for one
// cycle, the same cycle in which busy falls, with the index of the nearest center
// and its squared distance; equal sums go to the lowest index. The receiver cannot
// stall, so each result beat is taken in that cycle. Reset sets both registers to
// one and starts a fresh frame; center memory contents are undefined until loaded.
module nearest_center_assign #(
  parameter int MAX_CENTERS = nca_pkg::MaxCentersDef,
  parameter int MAX_DIM     = nca_pkg::MaxDimDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command_i,
  input  logic [nca_pkg::IdxW-1:0]         center_index_i,
  input  logic [nca_pkg::IdxW-1:0]         coord_index_i,
  input  logic signed [nca_pkg::ValueW-1:0] value_i,
  output logic                             done_o,
  output logic [nca_pkg::IdxW-1:0]         cluster_index_o,
  output logic [nca_pkg::SumW-1:0]         min_distance_sq_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nca_pkg::AddrW-1:0]        paddr,
  input  logic [nca_pkg::DataW-1:0]        pwdata,
  output logic [nca_pkg::DataW-1:0]        prdata,
  output logic                             pready
);

  localparam int IW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int PW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int Depth = MAX_CENTERS * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                          state_q, state_d;
  logic [nca_pkg::CfgW-1:0]      num_centers_q, vector_length_q;
  logic [PW-1:0]                 pos_q;
  logic signed [nca_pkg::ValueW-1:0] value_q;
  logic                          issuing_q;
  logic [IW-1:0]                 issue_c_q;
  logic [AW-1:0]                 addr_q;
  logic                          v1_q, v2_q, v3_q;
  logic [IW-1:0]                 c1_q, c2_q, c3_q;
  logic [nca_pkg::MagW-1:0]      mag2_q;
  logic [nca_pkg::SumW-1:0]      acc2_q, acc3_q;
  logic [nca_pkg::SqW-1:0]       sq3_q;
  logic [nca_pkg::SumW-1:0]      best_q;
  logic [IW-1:0]                 best_idx_q;
  logic                          done_q;

  logic                          cfg_we, accept, ctr_we, acc_re;
  logic [AW-1:0]                 ctr_waddr;
  logic [nca_pkg::ValueW-1:0]    ctr_rdata;
  logic [nca_pkg::SumW-1:0]      acc_rdata, acc_in;
  logic [IW-1:0]                 last_c;
  logic [PW-1:0]                 last_pos;
  logic signed [nca_pkg::ValueW:0] diff;
  logic [nca_pkg::MagW-1:0]      mag;
  logic [nca_pkg::SumW:0]        sum_wide;
  logic [nca_pkg::SumW-1:0]      sum_sat;
  logic                          at_last_pos, take, finish;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == nca_pkg::RegNumCenters) ?
                  nca_pkg::DataW'(num_centers_q) : nca_pkg::DataW'(vector_length_q);

  assign busy   = (state_q == StRun);
  assign accept = start & ~busy;
  assign ctr_we = accept & (command_i == nca_pkg::CmdLoad) &
                  (32'(center_index_i) < 32'(MAX_CENTERS)) &
                  (32'(coord_index_i) < 32'(MAX_DIM));
  assign ctr_waddr = AW'(32'(center_index_i) * 32'(MAX_DIM) + 32'(coord_index_i));
  assign acc_re = issuing_q;

  always_comb begin
    if (num_centers_q == '0) begin
      last_c = '0;
    end else if (32'(num_centers_q) > 32'(MAX_CENTERS)) begin
      last_c = IW'(MAX_CENTERS - 1);
    end else begin
      last_c = IW'(32'(num_centers_q) - 32'd1);
    end
    if (vector_length_q == '0) begin
      last_pos = '0;
    end else if (32'(vector_length_q) > 32'(MAX_DIM)) begin
      last_pos = PW'(MAX_DIM - 1);
    end else begin
      last_pos = PW'(32'(vector_length_q) - 32'd1);
    end
  end

  assign diff   = $signed({ctr_rdata[nca_pkg::ValueW-1], ctr_rdata}) -
                  $signed({value_q[nca_pkg::ValueW-1], value_q});
  assign mag    = diff[nca_pkg::ValueW] ? nca_pkg::MagW'(-diff) : nca_pkg::MagW'(diff);
  assign acc_in = (pos_q == '0) ? '0 : acc_rdata;

  assign sum_wide    = {1'b0, acc3_q} + (nca_pkg::SumW + 1)'(sq3_q);
  assign sum_sat     = sum_wide[nca_pkg::SumW] ? nca_pkg::SumMax : sum_wide[nca_pkg::SumW-1:0];
  assign at_last_pos = (pos_q == last_pos);
  assign take        = (c3_q == '0) || (sum_sat < best_q);
  assign finish      = v3_q & (c3_q == last_c);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && command_i == nca_pkg::CmdFrame) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      num_centers_q   <= nca_pkg::CfgW'(1);
      vector_length_q <= nca_pkg::CfgW'(1);
      pos_q           <= '0;
      issuing_q       <= 1'b0;
      issue_c_q       <= '0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      v3_q            <= 1'b0;
      done_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish & at_last_pos;
      v1_q    <= issuing_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (accept && command_i == nca_pkg::CmdFrame) begin
        issuing_q <= 1'b1;
        issue_c_q <= '0;
      end else if (issuing_q) begin
        if (issue_c_q == last_c) begin
          issuing_q <= 1'b0;
        end else begin
          issue_c_q <= issue_c_q + IW'(1);
        end
      end
      if (finish) begin
        pos_q <= at_last_pos ? '0 : pos_q + PW'(1);
      end
      if (cfg_we) begin
        pos_q <= '0;
        if (paddr[2] == nca_pkg::RegNumCenters) begin
          num_centers_q <= pwdata[nca_pkg::CfgW-1:0];
        end else begin
          vector_length_q <= pwdata[nca_pkg::CfgW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
      addr_q  <= AW'(pos_q);
    end else if (issuing_q) begin
      addr_q <= addr_q + AW'(MAX_DIM);
    end
    c1_q   <= issue_c_q;
    c2_q   <= c1_q;
    mag2_q <= mag;
    acc2_q <= acc_in;
    c3_q   <= c2_q;
    sq3_q  <= nca_pkg::SqW'(mag2_q) * nca_pkg::SqW'(mag2_q);
    acc3_q <= acc2_q;
    if (v3_q && at_last_pos && take) begin
      best_q     <= sum_sat;
      best_idx_q <= c3_q;
    end
  end

  assign done_o            = done_q;
  assign cluster_index_o   = nca_pkg::IdxW'(best_idx_q);
  assign min_distance_sq_o = best_q;

  nca_ram #(
    .WIDTH(nca_pkg::ValueW),
    .DEPTH(Depth)
  ) u_center_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(value_i),
    .re_i   (issuing_q),
    .raddr_i(addr_q),
    .rdata_o(ctr_rdata)
  );

  nca_ram #(
    .WIDTH(nca_pkg::SumW),
    .DEPTH(MAX_CENTERS)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (v3_q),
    .waddr_i(c3_q),
    .wdata_i(sum_sat),
    .re_i   (acc_re),
    .raddr_i(issue_c_q),
    .rdata_o(acc_rdata)
  );

  a_done_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a frame beat in progress");

  a_run_needs_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted beat");

  a_acc_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> busy)
    else $error("accumulator written outside a frame beat");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_we |-> !busy && !issuing_q)
    else $error("center memory written while a frame beat is at work");

endmodule

// ===== tb/nearest_center_check.sv =====
// Watcher for the nearest center block: predicts each frame result and compares it.
`timescale 1ns / 100ps

module nearest_center_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic                              command_i,
  input  logic [nca_pkg::IdxW-1:0]          center_index_i,
  input  logic [nca_pkg::IdxW-1:0]          coord_index_i,
  input  logic signed [nca_pkg::ValueW-1:0] value_i,
  input  logic                              done_i,
  input  logic [nca_pkg::IdxW-1:0]          cluster_index_i,
  input  logic [nca_pkg::SumW-1:0]          min_distance_sq_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [nca_pkg::AddrW-1:0]         paddr_i,
  input  logic [nca_pkg::DataW-1:0]         pwdata_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int NumCenters = nca_pkg::MaxCentersDef;
  localparam int NumCoords  = nca_pkg::MaxDimDef;

  typedef struct packed {
    logic [nca_pkg::IdxW-1:0] cluster;
    logic [nca_pkg::SumW-1:0] distance;
  } nearest_t;

  logic signed [nca_pkg::ValueW-1:0] center_table [NumCenters][NumCoords];
  logic [nca_pkg::SumW-1:0]          dist_sum [NumCenters];
  logic [nca_pkg::CfgW-1:0]          cfg_centers;
  logic [nca_pkg::CfgW-1:0]          cfg_length;
  int                                frame_pos;
  nearest_t                          nearest_q [$];
  int                                fails;

  function automatic int clamp_cfg(logic [nca_pkg::CfgW-1:0] raw, int hi);
    if (raw == 0) return 1;
    if (int'(raw) > hi) return hi;
    return int'(raw);
  endfunction

  task automatic clear_sums();
    int c;
    for (c = 0; c < NumCenters; c++) dist_sum[c] = '0;
    frame_pos = 0;
  endtask

  task automatic add_frame_coord(logic signed [nca_pkg::ValueW-1:0] coord);
    int                       n_used;
    int                       length;
    int                       pos;
    int                       c;
    int                       best;
    longint                   diff;
    logic [63:0]              total;
    logic [nca_pkg::SumW-1:0] best_sum;
    nearest_t                 hit;
    n_used = clamp_cfg(cfg_centers, NumCenters);
    length = clamp_cfg(cfg_length, NumCoords);
    pos = frame_pos;
    if (pos >= length) pos = length - 1;
    for (c = 0; c < n_used; c++) begin
      diff = longint'(center_table[c][pos]) - longint'(coord);
      if (diff < 0) diff = -diff;
      total = 64'(dist_sum[c]) + 64'(diff * diff);
      dist_sum[c] = (total > 64'(nca_pkg::SumMax)) ? nca_pkg::SumMax
                                                  : total[nca_pkg::SumW-1:0];
    end
    if (pos + 1 < length) begin
      frame_pos = pos + 1;
    end else begin
      best = 0;
      best_sum = dist_sum[0];
      for (c = 1; c < n_used; c++) begin
        if (dist_sum[c] < best_sum) begin
          best_sum = dist_sum[c];
          best = c;
        end
      end
      hit.cluster = best[nca_pkg::IdxW-1:0];
      hit.distance = best_sum;
      nearest_q.push_back(hit);
      clear_sums();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t want;
    if (!rst_ni) begin
      clear_sums();
      cfg_centers = 1;
      cfg_length = 1;
      nearest_q.delete();
      fails = 0;
    end else begin
      if (done_i) begin
        if (nearest_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result beat: cluster %0d distance %0d",
                     $time, cluster_index_i, min_distance_sq_i);
        end else begin
          want = nearest_q.pop_front();
          if (cluster_index_i !== want.cluster || min_distance_sq_i !== want.distance) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result mismatch: expected cluster %0d distance %0d, got cluster %0d distance %0d",
                       $time, want.cluster, want.distance, cluster_index_i, min_distance_sq_i);
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {nca_pkg::RegNumCenters, 2'b00}) begin
          cfg_centers = pwdata_i[nca_pkg::CfgW-1:0];
          clear_sums();
        end else if (paddr_i == {nca_pkg::RegVectorLength, 2'b00}) begin
          cfg_length = pwdata_i[nca_pkg::CfgW-1:0];
          clear_sums();
        end
      end
      if (start_i && !busy_i) begin
        if (command_i == nca_pkg::CmdLoad) center_table[center_index_i][coord_index_i] = value_i;
        else add_frame_coord(value_i);
      end
    end
    fail_count_o <= fails;
    pending_o <= nearest_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the nearest center testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit   = 1_000_000;
  localparam int RandomItems  = 1250;
  localparam int SettleCycles = 100;
  localparam int NumCenters   = nca_pkg::MaxCentersDef;
  localparam int NumCoords    = nca_pkg::MaxDimDef;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              command_i = nca_pkg::CmdLoad;
  logic [nca_pkg::IdxW-1:0]          center_index_i = '0;
  logic [nca_pkg::IdxW-1:0]          coord_index_i = '0;
  logic signed [nca_pkg::ValueW-1:0] value_i = '0;
  logic                              done_o;
  logic [nca_pkg::IdxW-1:0]          cluster_index_o;
  logic [nca_pkg::SumW-1:0]          min_distance_sq_o;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [nca_pkg::AddrW-1:0]         paddr = '0;
  logic [nca_pkg::DataW-1:0]         pwdata = '0;
  logic [nca_pkg::DataW-1:0]         prdata;
  logic                              pready;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int sent_count = 0;

  bit loaded [NumCenters][NumCoords];
  bit gaps_on;
  bit narrow_values;

  always #4 clk_i = ~clk_i;

  nearest_center_assign dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .center_index_i, .coord_index_i,
    .value_i, .done_o, .cluster_index_o, .min_distance_sq_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nearest_center_check nearest_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .center_index_i,
    .coord_index_i, .value_i, .done_i(done_o), .cluster_index_i(cluster_index_o),
    .min_distance_sq_i(min_distance_sq_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .pready_i(pready), .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending_results)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL nearest_center_assign");
      $finish;
    end
  end

  function automatic int clamp_raw(int raw);
    if (raw < 1) return 1;
    if (raw > NumCenters) return NumCenters;
    return raw;
  endfunction

  function automatic logic signed [nca_pkg::ValueW-1:0] pick_value();
    logic signed [nca_pkg::ValueW-1:0] v;
    int                                roll;
    roll = $urandom_range(0, 99);
    v = nca_pkg::ValueW'($urandom);
    if (narrow_values && roll < 70) begin
      v = nca_pkg::ValueW'(int'($urandom_range(0, 6)) - 3);
    end else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: v = 16'sh8000;
        1: v = 16'sh7FFF;
        2: v = 16'sh0000;
        default: v = 16'shFFFF;
      endcase
    end
    return v;
  endfunction

  task automatic send_item(logic cmd, int ci, int xi, logic signed [nca_pkg::ValueW-1:0] v);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 99) < 15) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    command_i = cmd;
    center_index_i = nca_pkg::IdxW'(ci);
    coord_index_i = nca_pkg::IdxW'(xi);
    value_i = v;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    sent_count++;
  endtask

  task automatic load_center(int ci, int xi, logic signed [nca_pkg::ValueW-1:0] v);
    send_item(nca_pkg::CmdLoad, ci, xi, v);
    loaded[ci][xi] = 1'b1;
  endtask

  task automatic frame_coord(logic signed [nca_pkg::ValueW-1:0] v);
    send_item(nca_pkg::CmdFrame, 0, 0, v);
  endtask

  // Lets the last frame beat finish, since a beat that ends no frame leaves nothing to wait on.
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic sel, logic [nca_pkg::CfgW-1:0] raw);
    logic [nca_pkg::DataW-1:0] data;
    data = $urandom;
    if ($urandom_range(0, 1) == 0) data = '0;
    data[nca_pkg::CfgW-1:0] = raw;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Every center entry that the new setting reads gets loaded before any frame beat.
  task automatic configure(int raw_centers, int raw_length);
    int c;
    int x;
    settle();
    reg_write(nca_pkg::RegNumCenters, nca_pkg::CfgW'(raw_centers));
    reg_write(nca_pkg::RegVectorLength, nca_pkg::CfgW'(raw_length));
    for (c = 0; c < clamp_raw(raw_centers); c++)
      for (x = 0; x < clamp_raw(raw_length); x++)
        if (!loaded[c][x]) load_center(c, x, pick_value());
  endtask

  initial begin
    int preset_centers [10];
    int preset_length [10];
    int raw_c;
    int raw_l;
    int phase;
    int beats;
    preset_centers = '{64, 1, 0, 127, 65, 2, 3, 64, 8, 100};
    preset_length  = '{1, 64, 3, 2, 4, 0, 127, 3, 8, 1};
    gaps_on = 1'b0;
    narrow_values = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_center(0, 0, 16'sh8000);
    frame_coord(16'sh7FFF);
    frame_coord(16'sh8000);
    frame_coord(16'sh0000);
    load_center(63, 63, 16'sh7FFF);
    load_center(63, 0, 16'shFFFF);
    load_center(0, 63, 16'sh8000);
    load_center(0, 1, 0);
    load_center(1, 0, 5);
    load_center(1, 1, 5);
    load_center(2, 0, 5);
    load_center(2, 1, 5);
    load_center(3, 0, 16'sh8000);
    load_center(3, 1, 16'sh7FFF);
    configure(4, 2);
    // Centers one and two are equal, so the lower index must win.
    frame_coord(5);
    frame_coord(5);
    // Center zero is reloaded in the middle of a frame and then ties with center three.
    frame_coord(16'sh8000);
    load_center(0, 1, 16'sh7FFF);
    frame_coord(16'sh7FFF);

    phase = 0;
    while (sent_count < RandomItems) begin
      if (phase < 10) begin
        raw_c = preset_centers[phase];
        raw_l = preset_length[phase];
      end else begin
        do begin
          raw_c = $urandom_range(0, 127);
          raw_l = $urandom_range(0, 127);
        end while (clamp_raw(raw_c) * clamp_raw(raw_l) > 256);
      end
      gaps_on = (phase % 5 != 1);
      narrow_values = ($urandom_range(0, 2) == 0);
      configure(raw_c, raw_l);
      beats = $urandom_range(60, 140);
      repeat (beats) begin
        if ($urandom_range(0, 99) < 80) frame_coord(pick_value());
        else load_center($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS nearest_center_assign");
    end else begin
      $display("FAIL nearest_center_assign");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nca_pkg.sv
rtl/nca_ram.sv
rtl/nearest_center_assign.sv
tb/nearest_center_check.sv
tb/testbench.sv
